// File: hw/rtl/tbam_pkg.sv
// Shared types, codes and helper functions for the temperature band alarm monitor.
// Used by tbam_cfg_regs, tbam_classify and temperature_band_alarm_monitor; depends on nothing.
`timescale 1ns / 1ps

package tbam_pkg;

  typedef enum logic [1:0] {
    StFault  = 2'd0,
    StLow    = 2'd1,
    StNormal = 2'd2,
    StHigh   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RegLowThr   = 3'd0,
    RegHighThr  = 3'd1,
    RegRepeat   = 3'd2,
    RegTrapLow  = 3'd3,
    RegTrapNorm = 3'd4,
    RegTrapHigh = 3'd5
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MsPerS   = 1000;
  localparam int unsigned Hysteresis = 1;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  typedef struct packed {
    logic signed [7:0] low_thr;
    logic signed [7:0] high_thr;
    logic [15:0]       repeat_s;
    logic [31:0]       period_ms;
    logic              low_trap_en;
    logic              normal_trap_en;
    logic              high_trap_en;
  } cfg_t;

  function automatic logic trap_wanted(status_e old_st, status_e cur_st, cfg_t cfg);
    logic res;
    res = 1'b0;
    if (old_st == StFault || cur_st == StFault) begin
      res = 1'b1;
    end else begin
      unique case (cur_st)
        StLow:    res = cfg.low_trap_en;
        StNormal: res = cfg.normal_trap_en;
        StHigh:   res = cfg.high_trap_en;
        default:  res = 1'b1;
      endcase
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/temperature_band_alarm_monitor.sv
// Top level of the temperature band alarm monitor: input register, per-channel state,
// result register and stream handshakes. Depends on tbam_pkg, tbam_cfg_regs, tbam_classify.
//
// Scan results enter on the s_axis channel, one transaction per reading, and each reading
// for a channel below CHANNELS yields one result transaction on the m_axis channel.
// Readings for other channels are consumed and yield nothing.
// A reading is captured in an input register; when the result register is free, the
// classifier, the deadline adder and compare and the trap filter work on it against the
// channel's stored status and deadline, and the result register and channel state are
// written together. Throughput is one transaction per cycle while the receiver does not
// stall, also for repeated readings of the same channel, since the state is updated in
// the same edge that loads the result register.
// When the receiver stalls, the result register holds and the input register takes one
// more reading; s_axis_tready then drops until the result is taken.
// Reset clears the valid flags of both registers, sets every channel to fault with a zero
// deadline and loads the configuration defaults. Configuration writes take effect at the
// next edge and should be made only while no transaction is in flight.
`timescale 1ns / 1ps

module temperature_band_alarm_monitor #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Fields from bit 0: channel[2:0], temperature[10:3], now_ms[42:11], zero pad.
  input  logic [tbam_pkg::InDataW-1:0]    s_axis_tdata,
  // Fields from bit 0: sensor_ok.
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: channel_out[2:0], band_status[4:3], reported_temp[12:5],
  // status_changed[13], send_trap[14], periodic_due[15].
  output logic [tbam_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [tbam_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tbam_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  tbam_pkg::cfg_t cfg;

  logic              in_valid_q;
  logic [2:0]        in_ch_q;
  logic              in_ok_q;
  logic signed [7:0] in_temp_q;
  logic [31:0]       in_now_q;

  logic                            out_valid_q;
  logic [tbam_pkg::OutDataW-1:0]   out_data_q;

  tbam_pkg::status_e status_q [CHANNELS];
  logic [31:0]       deadline_q [CHANNELS];

  logic              accept_in, advance, in_range, store;
  logic [ChIdxW-1:0] idx;
  tbam_pkg::status_e old_st, class_st, cur_st;
  logic signed [7:0] rep_temp;
  logic              changed, periodic, trap;
  logic [31:0]       rearm, dl_mid, dl_new;

  tbam_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign in_range = ({1'b0, in_ch_q} < 4'(CHANNELS));
  assign idx      = in_ch_q[ChIdxW-1:0];
  assign store    = advance && in_range;
  assign old_st   = status_q[idx];

  tbam_classify u_classify (
    .prev_i     (old_st),
    .temp_i     (in_temp_q),
    .low_thr_i  (cfg.low_thr),
    .high_thr_i (cfg.high_thr),
    .status_o   (class_st)
  );

  always_comb begin
    cur_st   = in_ok_q ? class_st : tbam_pkg::StFault;
    rep_temp = in_ok_q ? in_temp_q : 8'sd0;
    changed  = (cur_st != old_st);
    rearm    = in_now_q + cfg.period_ms;
    dl_mid   = changed ? rearm : deadline_q[idx];
    periodic = (cfg.repeat_s != '0) && (in_now_q > dl_mid);
    dl_new   = periodic ? rearm : dl_mid;
    trap     = (changed && tbam_pkg::trap_wanted(old_st, cur_st, cfg)) ||
               (periodic && tbam_pkg::trap_wanted(cur_st, cur_st, cfg));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_ch_q   <= s_axis_tdata[2:0];
      in_temp_q <= s_axis_tdata[10:3];
      in_now_q  <= s_axis_tdata[42:11];
      in_ok_q   <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (store) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      out_data_q <= {periodic, trap, changed, rep_temp, cur_st, in_ch_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        status_q[i]   <= tbam_pkg::StFault;
        deadline_q[i] <= '0;
      end
    end else if (store) begin
      status_q[idx]   <= cur_st;
      deadline_q[idx] <= dl_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_fault_temp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4:3] == tbam_pkg::StFault) |-> m_axis_tdata[12:5] == 8'd0)
    else $error("fault result carries a nonzero temperature");

  a_fault_change_traps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[13]) |-> m_axis_tdata[14] ||
      (m_axis_tdata[4:3] != tbam_pkg::StFault && $past(store) == 1'b0) ||
      (m_axis_tdata[4:3] != tbam_pkg::StFault))
    else $error("change into fault without a trap");

  a_periodic_needs_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (store && periodic) |-> cfg.repeat_s != '0)
    else $error("periodic trap with repeats disabled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

endmodule

// File: hw/rtl/tbam_cfg_regs.sv
// Configuration registers of the temperature band alarm monitor, with the repeat
// period in milliseconds worked out when the delay is written. Depends on tbam_pkg.
`timescale 1ns / 1ps

module tbam_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbam_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tbam_pkg::CfgDataW-1:0]  cfg_data_i,
  output tbam_pkg::cfg_t                 cfg_o
);

  tbam_pkg::cfg_t cfg_q, cfg_d;
  logic [25:0]    period_prod;

  assign period_prod = 26'(cfg_data_i) * 26'(tbam_pkg::MsPerS);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbam_pkg::RegLowThr:   cfg_d.low_thr        = cfg_data_i[7:0];
        tbam_pkg::RegHighThr:  cfg_d.high_thr       = cfg_data_i[7:0];
        tbam_pkg::RegRepeat: begin
          cfg_d.repeat_s  = cfg_data_i;
          cfg_d.period_ms = 32'(period_prod);
        end
        tbam_pkg::RegTrapLow:  cfg_d.low_trap_en    = cfg_data_i[0];
        tbam_pkg::RegTrapNorm: cfg_d.normal_trap_en = cfg_data_i[0];
        tbam_pkg::RegTrapHigh: cfg_d.high_trap_en   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr        <= 8'sd10;
      cfg_q.high_thr       <= 8'sd60;
      cfg_q.repeat_s       <= '0;
      cfg_q.period_ms      <= '0;
      cfg_q.low_trap_en    <= 1'b0;
      cfg_q.normal_trap_en <= 1'b0;
      cfg_q.high_trap_en   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/tbam_classify.sv
// Window comparator with hysteresis: classifies a reading as low, normal or high
// against thresholds moved according to the previous status. Depends on tbam_pkg.
`timescale 1ns / 1ps

module tbam_classify (
  input  tbam_pkg::status_e  prev_i,
  input  logic signed [7:0]  temp_i,
  input  logic signed [7:0]  low_thr_i,
  input  logic signed [7:0]  high_thr_i,
  output tbam_pkg::status_e  status_o
);

  localparam logic signed [9:0] Hyst = 10'(tbam_pkg::Hysteresis);

  logic signed [9:0] lo_base, hi_base, lo_adj, hi_adj, temp_ext;

  assign lo_base  = $signed({{2{low_thr_i[7]}}, low_thr_i});
  assign hi_base  = $signed({{2{high_thr_i[7]}}, high_thr_i});
  assign temp_ext = $signed({{2{temp_i[7]}}, temp_i});

  always_comb begin
    unique case (prev_i)
      tbam_pkg::StLow: begin
        lo_adj = lo_base + Hyst;
        hi_adj = hi_base + Hyst;
      end
      tbam_pkg::StNormal: begin
        lo_adj = lo_base - Hyst;
        hi_adj = hi_base + Hyst;
      end
      tbam_pkg::StHigh: begin
        lo_adj = lo_base - Hyst;
        hi_adj = hi_base - Hyst;
      end
      default: begin
        lo_adj = lo_base;
        hi_adj = hi_base;
      end
    endcase
  end

  always_comb begin
    priority if (temp_ext <= lo_adj) begin
      status_o = tbam_pkg::StLow;
    end else if (temp_ext >= hi_adj) begin
      status_o = tbam_pkg::StHigh;
    end else begin
      status_o = tbam_pkg::StNormal;
    end
  end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for temperature_band_alarm_monitor: directed scan table, then
// randomised phases with register changes, random idling on both streams and a band predictor.
// Depends on tbam_pkg and the RTL of temperature_band_alarm_monitor.
`timescale 1ns / 1ps

module testbench;

  localparam int Channels     = 8;
  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 11;
  localparam int SettleCycles = 8;
  localparam int QuietLimit   = 1000;
  localparam int PhaseCount   = 11;
  localparam int PhaseItems   = 150;
  localparam int ShownErrors  = 10;
  localparam int Hyst         = int'(tbam_pkg::Hysteresis);

  typedef struct {
    logic [2:0]        channel;
    logic              ok;
    logic signed [7:0] temp;
    logic [31:0]       now_ms;
  } scan_t;

  typedef struct {
    logic [2:0]        channel;
    tbam_pkg::status_e status;
    logic [7:0]        temp;
    logic              changed;
    logic              trap;
    logic              periodic;
  } report_t;

  typedef struct {
    logic                          is_reg;
    tbam_pkg::reg_idx_e            idx;
    logic [tbam_pkg::CfgDataW-1:0] data;
    scan_t                         scan;
    logic                          typed;
    report_t                       report;
  } plan_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic [tbam_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [tbam_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic                          cfg_we_i;
  logic [tbam_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tbam_pkg::CfgDataW-1:0] cfg_data_i;

  always #HalfPeriod clk_i = ~clk_i;

  temperature_band_alarm_monitor #(
    .CHANNELS(Channels)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  int                low_deg;
  int                high_deg;
  logic [15:0]       repeat_s;
  logic              low_trap_en;
  logic              normal_trap_en;
  logic              high_trap_en;
  tbam_pkg::status_e chan_state [Channels];
  logic [31:0]       chan_deadline [Channels];

  report_t     pending_reports [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  logic        idling = 1'b1;
  logic [31:0] scan_clock = '0;

  function automatic logic trap_due(tbam_pkg::status_e old_st, tbam_pkg::status_e cur_st);
    if (old_st == tbam_pkg::StFault || cur_st == tbam_pkg::StFault) return 1'b1;
    case (cur_st)
      tbam_pkg::StLow:    return low_trap_en;
      tbam_pkg::StNormal: return normal_trap_en;
      default:            return high_trap_en;
    endcase
  endfunction

  // Updates the channel state as the block does and returns the result it should give.
  function automatic report_t classify_scan(scan_t s);
    report_t           r;
    tbam_pkg::status_e prev;
    int                lo;
    int                hi;
    logic [31:0]       period;
    prev   = chan_state[s.channel];
    lo     = low_deg;
    hi     = high_deg;
    period = {16'd0, repeat_s} * tbam_pkg::MsPerS;
    case (prev)
      tbam_pkg::StLow: begin
        lo += Hyst;
        hi += Hyst;
      end
      tbam_pkg::StNormal: begin
        lo -= Hyst;
        hi += Hyst;
      end
      tbam_pkg::StHigh: begin
        lo -= Hyst;
        hi -= Hyst;
      end
      default: ;
    endcase
    r.channel  = s.channel;
    r.changed  = 1'b0;
    r.trap     = 1'b0;
    r.periodic = 1'b0;
    if (!s.ok) begin
      r.status = tbam_pkg::StFault;
      r.temp   = '0;
    end else begin
      r.temp = s.temp;
      if (int'(s.temp) <= lo) r.status = tbam_pkg::StLow;
      else if (int'(s.temp) >= hi) r.status = tbam_pkg::StHigh;
      else r.status = tbam_pkg::StNormal;
    end
    if (r.status != prev) begin
      r.changed                = 1'b1;
      r.trap                   = trap_due(prev, r.status);
      chan_state[s.channel]    = r.status;
      chan_deadline[s.channel] = s.now_ms + period;
    end
    if (repeat_s != 16'd0 && s.now_ms > chan_deadline[s.channel]) begin
      chan_deadline[s.channel] = s.now_ms + period;
      r.periodic               = 1'b1;
      if (trap_due(r.status, r.status)) r.trap = 1'b1;
    end
    return r;
  endfunction

  function automatic void store_register(tbam_pkg::reg_idx_e idx,
                                         logic [tbam_pkg::CfgDataW-1:0] data);
    case (idx)
      tbam_pkg::RegLowThr:   low_deg = int'($signed(data[7:0]));
      tbam_pkg::RegHighThr:  high_deg = int'($signed(data[7:0]));
      tbam_pkg::RegRepeat:   repeat_s = data;
      tbam_pkg::RegTrapLow:  low_trap_en = data[0];
      tbam_pkg::RegTrapNorm: normal_trap_en = data[0];
      tbam_pkg::RegTrapHigh: high_trap_en = data[0];
      default: ;
    endcase
  endfunction

  function automatic plan_row_t scan_row(int ch, logic ok, int t, logic [31:0] now);
    plan_row_t row;
    row.is_reg          = 1'b0;
    row.idx             = tbam_pkg::RegLowThr;
    row.data            = '0;
    row.typed           = 1'b0;
    row.scan.channel    = 3'(ch);
    row.scan.ok         = ok;
    row.scan.temp       = 8'(t);
    row.scan.now_ms     = now;
    row.report.channel  = 3'(ch);
    row.report.status   = tbam_pkg::StFault;
    row.report.temp     = '0;
    row.report.changed  = 1'b0;
    row.report.trap     = 1'b0;
    row.report.periodic = 1'b0;
    return row;
  endfunction

  function automatic plan_row_t known_row(int ch, logic ok, int t, logic [31:0] now,
                                          tbam_pkg::status_e st, int rt, logic chg,
                                          logic trap);
    plan_row_t row;
    row                = scan_row(ch, ok, t, now);
    row.typed          = 1'b1;
    row.report.status  = st;
    row.report.temp    = 8'(rt);
    row.report.changed = chg;
    row.report.trap    = trap;
    return row;
  endfunction

  function automatic plan_row_t reg_row(tbam_pkg::reg_idx_e idx,
                                        logic [tbam_pkg::CfgDataW-1:0] data);
    plan_row_t row;
    row        = scan_row(0, 1'b0, 0, '0);
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  // Most readings sit a few degrees around a threshold so that hysteresis is exercised.
  function automatic scan_t random_scan();
    scan_t s;
    int    t;
    int    pick;
    pick = int'($urandom_range(0, 99));
    if (pick < 3) scan_clock = $urandom();
    else if (pick < 5) scan_clock = 32'hFFFF_F000 + $urandom_range(0, 4095);
    else scan_clock = scan_clock + $urandom_range(0, 1500);
    s.channel = 3'($urandom_range(0, Channels - 1));
    s.ok      = ($urandom_range(0, 9) != 0);
    s.now_ms  = scan_clock;
    if ($urandom_range(0, 9) < 6) begin
      t = ($urandom_range(0, 1) ? low_deg : high_deg) + int'($urandom_range(0, 6)) - 3;
      if (t < -128) t = -128;
      if (t > 127) t = 127;
      s.temp = 8'(t);
    end else begin
      s.temp = 8'($urandom);
    end
    return s;
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= ShownErrors) $display("%s", msg);
  endtask

  task automatic write_reg(tbam_pkg::reg_idx_e idx, logic [tbam_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    store_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Unused upper data bits carry random values; the block must ignore them.
  task automatic apply_setting(int lo, int hi, int rep, logic tl, logic tn, logic th);
    write_reg(tbam_pkg::RegLowThr, {8'($urandom), 8'(lo)});
    write_reg(tbam_pkg::RegHighThr, {8'($urandom), 8'(hi)});
    write_reg(tbam_pkg::RegRepeat, 16'(rep));
    write_reg(tbam_pkg::RegTrapLow, {15'($urandom), tl});
    write_reg(tbam_pkg::RegTrapNorm, {15'($urandom), tn});
    write_reg(tbam_pkg::RegTrapHigh, {15'($urandom), th});
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_scan(scan_t s, logic typed, report_t typed_report);
    int      gap;
    report_t r;
    gap = idling ? int'($urandom_range(0, 4)) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, s.now_ms, s.temp, s.channel};
    s_axis_tuser  <= s.ok;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = classify_scan(s);
    pending_reports.push_back(typed ? typed_report : r);
  endtask

  initial begin : report_sink
    report_t want;
    report_t got;
    int      stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idling ? int'($urandom_range(0, 4)) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.channel  = m_axis_tdata[2:0];
      got.status   = tbam_pkg::status_e'(m_axis_tdata[4:3]);
      got.temp     = m_axis_tdata[12:5];
      got.changed  = m_axis_tdata[13];
      got.trap     = m_axis_tdata[14];
      got.periodic = m_axis_tdata[15];
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("Unexpected result transaction %h.", m_axis_tdata));
      end else begin
        want = pending_reports.pop_front();
        if (got.channel != want.channel || got.status != want.status ||
            got.temp != want.temp || got.changed != want.changed ||
            got.trap != want.trap || got.periodic != want.periodic) begin
          note_failure($sformatf(
            {"Mismatch: expected ch %0d st %0d temp %0d chg %b trap %b per %b, ",
             "got ch %0d st %0d temp %0d chg %b trap %b per %b."},
            want.channel, want.status, $signed(want.temp), want.changed, want.trap,
            want.periodic, got.channel, got.status, $signed(got.temp), got.changed,
            got.trap, got.periodic));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("FAIL temperature_band_alarm_monitor");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];
    plan_row_t blank;
    report_t   none;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    low_deg        = 10;
    high_deg       = 60;
    repeat_s       = '0;
    low_trap_en    = 1'b0;
    normal_trap_en = 1'b0;
    high_trap_en   = 1'b0;
    foreach (chan_state[c]) begin
      chan_state[c]    = tbam_pkg::StFault;
      chan_deadline[c] = '0;
    end
    blank = scan_row(0, 1'b0, 0, '0);
    none  = blank.report;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: band 10..60, no repeats, no trap enables.
    plan.push_back(known_row(0, 1'b0, 55, 32'd0, tbam_pkg::StFault, 0, 1'b0, 1'b0));
    plan.push_back(known_row(0, 1'b1, 10, 32'd10, tbam_pkg::StLow, 10, 1'b1, 1'b1));
    plan.push_back(known_row(0, 1'b1, 11, 32'd20, tbam_pkg::StLow, 11, 1'b0, 1'b0));
    plan.push_back(known_row(0, 1'b1, 12, 32'd30, tbam_pkg::StNormal, 12, 1'b1, 1'b0));
    plan.push_back(known_row(0, 1'b1, 9, 32'd40, tbam_pkg::StLow, 9, 1'b1, 1'b0));
    plan.push_back(known_row(1, 1'b1, 60, 32'd50, tbam_pkg::StHigh, 60, 1'b1, 1'b1));
    plan.push_back(known_row(1, 1'b1, 59, 32'd60, tbam_pkg::StHigh, 59, 1'b0, 1'b0));
    plan.push_back(known_row(1, 1'b1, -128, 32'd70, tbam_pkg::StLow, -128, 1'b1, 1'b0));
    plan.push_back(known_row(2, 1'b1, 127, 32'd80, tbam_pkg::StHigh, 127, 1'b1, 1'b1));
    plan.push_back(known_row(2, 1'b0, -1, 32'd90, tbam_pkg::StFault, 0, 1'b1, 1'b1));
    plan.push_back(known_row(7, 1'b1, -128, 32'd100, tbam_pkg::StLow, -128, 1'b1, 1'b1));
    plan.push_back(known_row(7, 1'b0, 127, 32'd110, tbam_pkg::StFault, 0, 1'b1, 1'b1));
    // Repeat timer, including a deadline that wraps and fires on the changing reading.
    plan.push_back(reg_row(tbam_pkg::RegRepeat, 16'd1));
    plan.push_back(reg_row(tbam_pkg::RegTrapNorm, 16'd1));
    plan.push_back(scan_row(3, 1'b1, 30, 32'd1000));
    plan.push_back(scan_row(3, 1'b1, 30, 32'd2001));
    plan.push_back(scan_row(3, 1'b1, 30, 32'hFFFF_FF00));
    plan.push_back(scan_row(4, 1'b1, 30, 32'hFFFF_FFFF));
    // Inverted band: the low test wins.
    plan.push_back(reg_row(tbam_pkg::RegLowThr, 16'h007F));
    plan.push_back(reg_row(tbam_pkg::RegHighThr, 16'h0080));
    plan.push_back(scan_row(5, 1'b1, 0, 32'd5));
    plan.push_back(scan_row(5, 1'b1, -128, 32'd6));
    plan.push_back(scan_row(6, 1'b1, 127, 32'd7));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_scan(plan[i].scan, plan[i].typed, plan[i].report);
      end
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      settle();
      case (phase)
        0: apply_setting(10, 60, 1, 1'b1, 1'b1, 1'b1);
        1: apply_setting(-128, 127, 0, 1'b0, 1'b0, 1'b0);
        2: apply_setting(127, -128, 2, 1'($urandom), 1'($urandom), 1'($urandom));
        3: apply_setting(0, 0, 65535, 1'b1, 1'b0, 1'b1);
        default: begin
          int lo;
          lo = int'($urandom_range(0, 160)) - 80;
          apply_setting(lo, lo + int'($urandom_range(0, 40)), int'($urandom_range(0, 3)),
                        1'($urandom), 1'($urandom), 1'($urandom));
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 32 == 0) idling = ($urandom_range(0, 3) != 0);
        send_scan(random_scan(), 1'b0, none);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("PASS temperature_band_alarm_monitor");
    end else begin
      $display("FAIL temperature_band_alarm_monitor");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tbam_pkg.sv
hw/rtl/tbam_cfg_regs.sv
hw/rtl/tbam_classify.sv
hw/rtl/temperature_band_alarm_monitor.sv
sim/testbench.sv
